// ----- hdl/chte_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// Shared codes and constants for the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

  localparam int HASH_W      = 64;
  localparam int RESULT_W    = 32;
  localparam int MOD_DIGIT_W = 16;
  localparam int MOD_STEPS   = HASH_W / MOD_DIGIT_W;
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

endpackage

// ----- hdl/chte_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/chte_mod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_mod
// Multi-cycle remainder of a 64-bit hash by the table size, sixteen bits per
// step (quotient estimate, then correction) by reciprocal multiplication.
// ----------------------------------------------------------------------------
module chte_mod #(
  parameter int CAPACITY = 256,
  parameter int BW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [chte_pkg::HASH_W-1:0] hash,
  output logic                       done,
  output logic [BW-1:0]              rem
);
  import chte_pkg::*;

  localparam int TW = 2 * MOD_DIGIT_W;
  localparam int RW = MOD_DIGIT_W + 1;
  localparam logic [TW:0]   RECIP = (TW+1)'((64'd1 << TW) / 64'(CAPACITY));
  localparam logic [RW-1:0] CAP   = RW'(CAPACITY);

  logic [HASH_W-1:0]    shreg;
  logic [MOD_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 phase;
  logic [TW-1:0]        t_next;
  logic [TW-1:0]        t_reg;
  logic [TW-1:0]        quot;
  logic [TW-1:0]        quot_next;
  logic [2*TW:0]        prod;
  logic [TW-1:0]        qc;
  logic [TW-1:0]        diff;
  logic [RW-1:0]        r;
  logic [BW-1:0]        rem_next;

  // partial remainder shifted up by one digit, next digit below
  assign t_next    = {MOD_DIGIT_W'(rem), shreg[HASH_W-1 -: MOD_DIGIT_W]};
  // quotient estimate is exact or one short
  assign prod      = (2*TW+1)'(t_next) * (2*TW+1)'(RECIP);
  assign quot_next = prod[2*TW-1:TW];
  assign qc        = TW'((TW+RW)'(quot) * (TW+RW)'(CAP));
  assign diff      = t_reg - qc;

  always_comb begin
    r = diff[RW-1:0];
    if (r >= CAP) begin
      r = r - CAP;
    end
    rem_next = r[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          cnt <= cnt + 1'b1;
          if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= hash;
      rem   <= '0;
    end else if (busy) begin
      if (!phase) begin
        t_reg <= t_next;
        quot  <= quot_next;
        shreg <= shreg << MOD_DIGIT_W;
      end else begin
        rem <= rem_next;
      end
    end
  end

endmodule

// ----- hdl/chained_hash_table_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Hash table with separate chaining over a slot memory and a free list.
// ----------------------------------------------------------------------------
// After reset the block clears every bucket head and takes no request in
// that time. Requests are handled one item at a time: the bucket index comes
// from a remainder unit that folds in sixteen hash bits per step by
// reciprocal multiplication. An add then passes through S_HEAD and S_ADD; a
// remove or lookup passes through S_HEAD and S_FIRST, then S_FETCH and S_CMP
// per chain link visited (slot memory read then hash compare), a final
// S_FETCH when the walk reaches the chain end and S_FREE for the free-list
// write on a remove hit. The result item moves to the output register once
// that register is free, and from then on a new request is taken while the
// result waits there.
module chained_hash_table_engine #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,  // key_hash[63:0], new_value[95:64]
  input  logic [1:0]   s_tuser,  // req_type[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata   // status[1:0], found[2], read_value[34:3], zero
);
  import chte_pkg::*;

  localparam int BW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int WW = HASH_W + VALUE_WIDTH + SW;
  localparam logic [SW-1:0] EMPTY = SW'(CAPACITY);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MOD   = 9'b000000100,
    S_HEAD  = 9'b000001000,
    S_ADD   = 9'b000010000,
    S_FIRST = 9'b000100000,
    S_FETCH = 9'b001000000,
    S_CMP   = 9'b010000000,
    S_FREE  = 9'b100000000
  } state_t;

  state_t state;

  logic [1:0]             req;
  logic [HASH_W-1:0]      hash;
  logic [VALUE_WIDTH-1:0] val;
  logic [BW-1:0]          bucket;
  logic [BW-1:0]          clr_cnt;
  logic [SW-1:0]          free_head;
  logic [SW-1:0]          next_unused;
  logic [SW-1:0]          cur;
  logic [SW-1:0]          par;
  logic [SW-1:0]          steps;
  logic [WW-1:0]          par_word;

  logic [1:0]             res_status;
  logic                   res_found;
  logic [RESULT_W-1:0]    res_value;
  logic                   res_pend;

  logic                   mod_done;
  logic [BW-1:0]          mod_rem;

  logic                   bh_we;
  logic [BW-1:0]          bh_waddr;
  logic [SW-1:0]          bh_wdata;
  logic [BW-1:0]          bh_raddr;
  logic [SW-1:0]          bh_rdata;

  logic                   sl_we;
  logic [BW-1:0]          sl_waddr;
  logic [WW-1:0]          sl_wdata;
  logic [BW-1:0]          sl_raddr;
  logic [WW-1:0]          sl_rdata;

  logic [HASH_W-1:0]      rd_hash;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [SW-1:0]          rd_link;
  logic                   hit;
  logic                   accept;

  assign rd_hash = sl_rdata[HASH_W-1:0];
  assign rd_val  = sl_rdata[HASH_W +: VALUE_WIDTH];
  assign rd_link = sl_rdata[HASH_W+VALUE_WIDTH +: SW];
  assign hit     = (rd_hash == hash);

  // a finished result must reach the output register before the next item
  assign s_tready = (state == S_IDLE) && !res_pend;
  assign accept   = s_tvalid && s_tready;

  chte_mod #(.CAPACITY(CAPACITY), .BW(BW)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .hash  (s_tdata[HASH_W-1:0]),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  chte_ram #(.WIDTH(SW), .DEPTH(CAPACITY), .AW(BW)) u_heads (
    .clk     (clk),
    .wr_en   (bh_we),
    .wr_addr (bh_waddr),
    .wr_data (bh_wdata),
    .rd_addr (bh_raddr),
    .rd_data (bh_rdata)
  );

  chte_ram #(.WIDTH(WW), .DEPTH(CAPACITY), .AW(BW)) u_slots (
    .clk     (clk),
    .wr_en   (sl_we),
    .wr_addr (sl_waddr),
    .wr_data (sl_wdata),
    .rd_addr (sl_raddr),
    .rd_data (sl_rdata)
  );

  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = bucket;
    bh_wdata = rd_link;
    bh_raddr = bucket;
    sl_we    = 1'b0;
    sl_waddr = cur[BW-1:0];
    sl_wdata = {free_head, {VALUE_WIDTH{1'b0}}, {HASH_W{1'b0}}};
    sl_raddr = (state == S_HEAD) ? free_head[BW-1:0] : cur[BW-1:0];
    case (state)
      S_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clr_cnt;
        bh_wdata = EMPTY;
      end
      S_ADD: begin
        if (free_head != EMPTY) begin
          bh_we    = 1'b1;
          bh_wdata = free_head;
          sl_we    = 1'b1;
          sl_waddr = free_head[BW-1:0];
        end else if (next_unused != EMPTY) begin
          bh_we    = 1'b1;
          bh_wdata = next_unused;
          sl_we    = 1'b1;
          sl_waddr = next_unused[BW-1:0];
        end
        sl_wdata = {bh_rdata, val, hash};
      end
      S_CMP: begin
        // unlink the match from its predecessor or from the bucket head
        if (hit && req == REQ_REMOVE) begin
          if (par == EMPTY) begin
            bh_we = 1'b1;
          end else begin
            sl_we    = 1'b1;
            sl_waddr = par[BW-1:0];
            sl_wdata = {rd_link, par_word[HASH_W +: VALUE_WIDTH],
                        par_word[HASH_W-1:0]};
          end
        end
      end
      S_FREE: begin
        sl_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      free_head   <= EMPTY;
      next_unused <= '0;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
      res_pend    <= 1'b0;
    end else begin
      if (res_pend && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'b0, res_value, res_found, res_status};
        res_pend <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == BW'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (req == REQ_ADD) begin
            state <= S_ADD;
          end else if (req == REQ_NOP) begin
            res_pend <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_FIRST;
          end
        end
        S_ADD: begin
          if (free_head != EMPTY) begin
            free_head <= rd_link;
          end else if (next_unused != EMPTY) begin
            next_unused <= next_unused + 1'b1;
          end
          res_pend <= 1'b1;
          state    <= S_IDLE;
        end
        S_FIRST: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (cur == EMPTY || steps == EMPTY) begin
            res_pend <= 1'b1;
            state    <= S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            if (req == REQ_REMOVE) begin
              state <= S_FREE;
            end else begin
              res_pend <= 1'b1;
              state    <= S_IDLE;
            end
          end else begin
            state <= S_FETCH;
          end
        end
        S_FREE: begin
          free_head <= cur;
          res_pend  <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and chain walk registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= s_tuser;
      hash       <= s_tdata[HASH_W-1:0];
      val        <= VALUE_WIDTH'(s_tdata[95:64]);
      res_status <= ST_DONE;
      res_found  <= 1'b0;
      res_value  <= '0;
    end
    if (mod_done) begin
      bucket <= mod_rem;
    end
    case (state)
      S_ADD: begin
        if (free_head == EMPTY && next_unused == EMPTY) begin
          res_status <= ST_FULL;
        end
      end
      S_FIRST: begin
        cur   <= bh_rdata;
        par   <= EMPTY;
        steps <= '0;
      end
      S_FETCH: begin
        if (cur == EMPTY || steps == EMPTY) begin
          res_status <= ST_NOTFOUND;
        end
      end
      S_CMP: begin
        if (hit) begin
          res_found <= 1'b1;
          if (req == REQ_LOOKUP) begin
            res_value <= RESULT_W'(HASH_W'(rd_val));
          end
        end else begin
          par      <= cur;
          par_word <= sl_rdata;
          cur      <= rd_link;
          steps    <= steps + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
